// ===== design/i2cts_pkg.sv =====
package i2cts_pkg;

	// Request kinds carried on the input tuser.
	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_BEGIN = 2'd2,
		MODE_EVENT = 2'd3
	} mode_t;

	// Bus status events as the controller reports them.
	typedef enum logic [3:0] {
		EV_START      = 4'd0,
		EV_RSTART     = 4'd1,
		EV_ARB_LOST   = 4'd2,
		EV_SLAW_ACK   = 4'd3,
		EV_SLAW_NACK  = 4'd4,
		EV_TXDATA_ACK = 4'd5,
		EV_TXDATA_NAK = 4'd6,
		EV_SLAR_ACK   = 4'd7,
		EV_SLAR_NACK  = 4'd8,
		EV_RXDATA_ACK = 4'd9,
		EV_RXDATA_NAK = 4'd10,
		EV_OTHER      = 4'd11
	} event_t;

	// Transaction status codes.
	typedef enum logic [1:0] {
		ST_BUSY    = 2'd0,
		ST_STOPPED = 2'd1,
		ST_PAUSED  = 2'd2
	} status_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_TRANSFER_LENGTH    = 2'd0;
	localparam logic [1:0] REG_STOP_AT_END        = 2'd1;
	localparam logic [1:0] REG_NACK_ENDS_NORMALLY = 2'd2;

	localparam int unsigned LEN_W   = 6;
	localparam int unsigned INDEX_W = 5;
	localparam int unsigned BYTE_W  = 8;

	// Controller command and notifications for one request.
	typedef struct packed {
		logic    load_tx;
		logic    release_bus;
		logic    send_stop;
		logic    ack_next;
		logic    done_res;
		logic    fault;
		status_t status;
		logic    read_sel;
	} cmd_t;

endpackage

// ===== design/i2cts_buffer.sv =====
module i2cts_buffer
	import i2cts_pkg::*;
#(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rd_data_s1
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_s1 <= mem[raddr];
		end
	end

endmodule

// ===== design/i2cts_ctrl.sv =====
module i2cts_ctrl
	import i2cts_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 32,
	parameter int unsigned AW           = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [LEN_W-1:0]  cfg_wdata,
	input  logic              accept,
	input  logic [1:0]        mode,
	input  logic [INDEX_W-1:0] index,
	input  logic [BYTE_W-1:0] value,
	input  logic [3:0]        event_code,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [BYTE_W-1:0] mem_wdata,
	output logic [AW-1:0]     mem_raddr,
	output cmd_t              cmd_s1
);

	localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned CW = ((PW > LEN_W) ? PW : LEN_W) + 2;
	localparam int unsigned XW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

	logic [LEN_W-1:0] transfer_length_q;
	logic             stop_at_end_q;
	logic             nack_ends_normally_q;
	logic [PW-1:0]    position_q;
	status_t          status_q;

	logic [PW-1:0] position_d;
	status_t       status_d;
	cmd_t          cmd;
	logic          wr_req;
	logic          wr_at_pos;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] len_c;
	logic          pos_ge_len;
	logic          pos_end;
	logic          ack_cur;
	logic          ack_inc;
	logic [XW-1:0] idx_x;
	logic          idx_ok;
	mode_t         mode_v;
	event_t        ev_v;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transfer_length_q    <= LEN_W'(1);
			stop_at_end_q        <= 1'b1;
			nack_ends_normally_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRANSFER_LENGTH:    transfer_length_q    <= cfg_wdata;
				REG_STOP_AT_END:        stop_at_end_q        <= cfg_wdata[0];
				REG_NACK_ENDS_NORMALLY: nack_ends_normally_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Compares on position and transfer length.
	always_comb begin
		mode_v     = mode_t'(mode);
		ev_v       = event_t'(event_code);
		pos_c      = CW'(position_q);
		len_c      = CW'(transfer_length_q);
		pos_ge_len = pos_c >= len_c;
		pos_end    = pos_c >= CW'(BUFFER_DEPTH);
		ack_cur    = (pos_c + CW'(1)) < len_c;
		ack_inc    = (pos_c + CW'(2)) < len_c;
		idx_x      = XW'(index);
		idx_ok     = idx_x < XW'(BUFFER_DEPTH);
	end

	// Decode of one request into the next state and the controller command.
	always_comb begin
		position_d = position_q;
		status_d   = status_q;
		cmd        = '0;
		wr_req     = 1'b0;
		wr_at_pos  = 1'b0;
		case (mode_v)
			MODE_LOAD: begin
				wr_req = idx_ok;
			end
			MODE_READ: begin
				cmd.read_sel = idx_ok;
			end
			MODE_BEGIN: begin
				position_d = '0;
				status_d   = ST_BUSY;
			end
			default: begin
				case (ev_v)
					EV_START, EV_RSTART, EV_SLAW_ACK, EV_TXDATA_ACK: begin
						if (ev_v == EV_TXDATA_ACK && pos_ge_len) begin
							// All bytes sent: end of transaction.
							cmd.done_res = 1'b1;
							if (stop_at_end_q) begin
								cmd.release_bus = 1'b1;
								cmd.send_stop   = 1'b1;
								status_d        = ST_STOPPED;
							end else begin
								status_d = ST_PAUSED;
							end
						end else if (pos_end) begin
							cmd.release_bus = 1'b1;
							cmd.send_stop   = 1'b1;
							cmd.fault       = 1'b1;
						end else begin
							cmd.load_tx     = 1'b1;
							cmd.release_bus = 1'b1;
							position_d      = position_q + PW'(1);
						end
					end
					EV_TXDATA_NAK: begin
						cmd.release_bus = 1'b1;
						cmd.send_stop   = 1'b1;
						cmd.done_res    = nack_ends_normally_q;
						cmd.fault       = !nack_ends_normally_q;
					end
					EV_SLAR_ACK: begin
						if (pos_ge_len) begin
							cmd.done_res = 1'b1;
							if (stop_at_end_q) begin
								cmd.release_bus = 1'b1;
								cmd.send_stop   = 1'b1;
								status_d        = ST_STOPPED;
							end else begin
								status_d = ST_PAUSED;
							end
						end else begin
							cmd.release_bus = 1'b1;
							cmd.ack_next    = ack_cur;
						end
					end
					EV_RXDATA_ACK, EV_RXDATA_NAK: begin
						if (pos_end) begin
							cmd.release_bus = 1'b1;
							cmd.send_stop   = 1'b1;
							cmd.fault       = 1'b1;
						end else if (ev_v == EV_RXDATA_ACK) begin
							wr_req          = 1'b1;
							wr_at_pos       = 1'b1;
							position_d      = position_q + PW'(1);
							cmd.release_bus = 1'b1;
							cmd.ack_next    = ack_inc;
						end else begin
							// Last byte received: store it and end the transaction.
							wr_req       = 1'b1;
							wr_at_pos    = 1'b1;
							cmd.done_res = 1'b1;
							if (stop_at_end_q) begin
								cmd.release_bus = 1'b1;
								cmd.send_stop   = 1'b1;
								status_d        = ST_STOPPED;
							end else begin
								status_d = ST_PAUSED;
							end
						end
					end
					default: begin
						// Arbitration lost, address nack and unknown events abort.
						cmd.release_bus = 1'b1;
						cmd.send_stop   = 1'b1;
						cmd.fault       = 1'b1;
					end
				endcase
			end
		endcase
		cmd.status = status_d;
	end

	// Buffer access: loads and reads use the index, bus events the position.
	always_comb begin
		mem_we    = accept && wr_req;
		mem_waddr = wr_at_pos ? AW'(position_q) : AW'(idx_x);
		mem_wdata = value;
		mem_raddr = (mode_v == MODE_READ) ? AW'(idx_x) : AW'(position_q);
	end

	// Transaction state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			status_q   <= ST_BUSY;
		end else if (accept) begin
			position_q <= position_d;
			status_q   <= status_d;
		end
	end

	// Command register, aligned with the buffer read data.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

// ===== design/i2c_master_transaction_sequencer.sv =====
// Channel   Direction  Bits                      Contents
// s_axis    in         tuser[1:0], tdata[23:0]   request kind; index, value, event code
// m_axis    out        tdata[23:0]               controller command, status, read byte
// cfg       in         we, index[1:0], wdata[5:0] transfer length, stop at end, nack end
//
// Every request gives one result; the edge that takes it stores the command and
// the buffer read, and the output register is filled from them when the decode
// stage advances. A request is taken every cycle unless the output stalls.
// Reset clears position and status and sets the configuration to its defaults;
// buffer contents are kept. A stalled output holds its result while one more request is taken behind it.
module i2c_master_transaction_sequencer
	import i2cts_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // index[4:0], value[12:5], event_code[16:13]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // tx_byte[7:0], load_tx[8], release_bus[9],
	                                   // send_stop[10], ack_next[11], done_res[12],
	                                   // fault[13], status[15:14], read_byte[23:16]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_wdata
);

	localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic              accept;
	logic              advance;
	logic              s1_valid_q;
	logic              m_valid_q;
	logic [23:0]       m_data_q;
	cmd_t              cmd_s1;
	logic [BYTE_W-1:0] rd_data_s1;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] tx_byte;
	logic [BYTE_W-1:0] read_byte;

	// Handshake: decode stage drains into the output register.
	assign advance       = s1_valid_q && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	i2cts_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.mode      (s_axis_tuser),
		.index     (s_axis_tdata[4:0]),
		.value     (s_axis_tdata[12:5]),
		.event_code(s_axis_tdata[16:13]),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.cmd_s1    (cmd_s1)
	);

	i2cts_buffer #(
		.DEPTH(BUFFER_DEPTH),
		.AW   (AW)
	) u_buffer (
		.clk       (clk),
		.we        (mem_we),
		.waddr     (mem_waddr),
		.wdata     (mem_wdata),
		.re        (accept),
		.raddr     (mem_raddr),
		.rd_data_s1(rd_data_s1)
	);

	// The buffer byte goes to the send field or the read field.
	assign tx_byte   = cmd_s1.load_tx  ? rd_data_s1 : '0;
	assign read_byte = cmd_s1.read_sel ? rd_data_s1 : '0;

	// Valid flags of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {read_byte, cmd_s1.status, cmd_s1.fault, cmd_s1.done_res,
				cmd_s1.ack_next, cmd_s1.send_stop, cmd_s1.release_bus,
				cmd_s1.load_tx, tx_byte};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule
